// ===== rtl/core/amr_payload_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// amr_payload_deframer_macros.svh
// Assertion macros shared by the deframer RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AMR_PAYLOAD_DEFRAMER_MACROS_SVH
`define AMR_PAYLOAD_DEFRAMER_MACROS_SVH

`ifndef SYNTH
`define AMR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amr_payload_deframer: assertion failed");
`define AMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amr_payload_deframer: assertion failed");
`else
`define AMR_ASSERT_IMPL(label, ante, cons)
`define AMR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/amrpd_pkg.sv =====
// ----------------------------------------------------------------------------
// amrpd_pkg
// Types, codes and the speech size table of the AMR payload deframer.
// ----------------------------------------------------------------------------
package amrpd_pkg;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_BIT     = 3'd2;
  localparam logic [2:0] OP_OPEN_RD = 3'd3;
  localparam logic [2:0] OP_OPEN_EV = 3'd4;
  localparam logic [2:0] OP_FINISH  = 3'd5;

  localparam logic [1:0] PH_CMR    = 2'd0;
  localparam logic [1:0] PH_TOC    = 2'd1;
  localparam logic [1:0] PH_SPEECH = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_SUM  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OVF   = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  localparam logic REG_OCTET = 1'b0;
  localparam logic REG_INIT  = 1'b1;

  localparam logic [3:0] FT_NO_DATA = 4'd14;
  localparam int         RES_CAP    = 20;

  typedef struct packed {
    logic [2:0] op;
  } amrpd_cmd_t;

  typedef struct packed {
    logic hold;
    logic open_next;
    logic frame_avail;
    logic ev_advance;
    logic end_flag;
  } amrpd_sts_t;

  typedef struct packed {
    logic       octet_we;
    logic       init_we;
    logic [2:0] value;
  } amrpd_cfg_t;

  function automatic logic [7:0] frame_bit_len(input logic [3:0] ft, input logic octet);
    logic [7:0] n;
    case (ft)
      4'd0:    n = 8'd95;
      4'd1:    n = 8'd103;
      4'd2:    n = 8'd118;
      4'd3:    n = 8'd134;
      4'd4:    n = 8'd148;
      4'd5:    n = 8'd159;
      4'd6:    n = 8'd204;
      4'd7:    n = 8'd244;
      default: n = 8'd0;
    endcase
    if (octet) n = (n + 8'd7) & 8'hF8;
    return n;
  endfunction

endpackage

// ===== rtl/core/amrpd_ram.sv =====
// ----------------------------------------------------------------------------
// amrpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amrpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/amrpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// amrpd_ctrl
// Sequencer: takes an item, steps its eight bits, walks frame openings and
// issues the packet summary.
// ----------------------------------------------------------------------------
module amrpd_ctrl
  import amrpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  amrpd_sts_t sts,
  output amrpd_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BIT  = 3'd1;
  localparam logic [2:0] S_ORD  = 3'd2;
  localparam logic [2:0] S_OEV  = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [3:0] left_r, left_nxt;
  logic [2:0] cont_state;

  assign cont_state = (left_r != 4'd0) ? S_BIT : (sts.end_flag ? S_END : S_IDLE);

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_BIT;
          left_nxt  = 4'd8;
        end
      end
      S_BIT: begin
        cmd.op = OP_BIT;
        if (!sts.hold) begin
          left_nxt = left_r - 4'd1;
          if (sts.open_next) state_nxt = S_ORD;
          else if (left_r == 4'd1) state_nxt = sts.end_flag ? S_END : S_IDLE;
        end
      end
      S_ORD: begin
        cmd.op    = OP_OPEN_RD;
        state_nxt = sts.frame_avail ? S_OEV : cont_state;
      end
      S_OEV: begin
        cmd.op = OP_OPEN_EV;
        if (!sts.hold) state_nxt = sts.ev_advance ? S_ORD : cont_state;
      end
      S_END: begin
        cmd.op = OP_FINISH;
        if (!sts.hold) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= 4'd0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ===== rtl/core/amrpd_dp.sv =====
// ----------------------------------------------------------------------------
// amrpd_dp
// Datapath: bit gathering, TOC store, frame and speech counters, result
// register and configuration registers.
// ----------------------------------------------------------------------------
module amrpd_dp
  import amrpd_pkg::*;
#(
  parameter int MAX_FRAMES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  amrpd_cmd_t cmd,
  output amrpd_sts_t sts,
  input  amrpd_cfg_t cfg,
  output logic       cfg_octet,
  output logic [2:0] cfg_init,
  input  logic [7:0] in_byte,
  input  logic       in_packet_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [3:0] out_frame_index,
  output logic [3:0] out_frame_type,
  output logic       out_quality,
  output logic       out_frame_last,
  output logic [3:0] out_cmr_value,
  output logic [4:0] out_frame_total,
  output logic [2:0] out_req_mode_now,
  output logic [1:0] out_status
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_FRAMES);

  logic             octet_r;
  logic [2:0]       init_r;
  logic [7:0]       byte_r, byte_nxt;
  logic             end_r, end_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       buf_r, buf_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0] toc_cnt_r, toc_cnt_nxt;
  logic [CNT_W-1:0] cur_r, cur_nxt;
  logic [7:0]       left_r, left_nxt;
  logic [3:0]       cmr_r, cmr_nxt;
  logic [2:0]       req_r, req_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [4:0]       entry_r, entry_nxt;
  logic [4:0]       res_n_r, res_n_nxt;

  logic             out_valid_r;
  logic [1:0]       o_kind_r, e_kind;
  logic [7:0]       o_data_r, e_data;
  logic [3:0]       o_idx_r, e_idx;
  logic [3:0]       o_ft_r, e_ft;
  logic             o_q_r, e_q;
  logic             o_last_r, e_last;
  logic [3:0]       o_cmr_r, e_cmr;
  logic [4:0]       o_total_r, e_total;
  logic [2:0]       o_mode_r, e_mode;
  logic [1:0]       o_stat_r, e_stat;
  logic             emit, out_free, room;

  logic [7:0]       nb;
  logic [3:0]       nc;
  logic [3:0]       cmr_need, toc_need;
  logic [3:0]       cmr_ext, toc_ft;
  logic             toc_f, toc_q;
  logic [CNT_W-1:0] toc_after;
  logic [7:0]       left_dec, sp_data;
  logic [4:0]       ev_e;
  logic [3:0]       ev_ft;
  logic [7:0]       ev_nb;
  logic [1:0]       err_fin;
  logic [2:0]       req_fin;

  logic             ram_we, ram_re;
  logic [4:0]       ram_wdata, ram_rdata;

  amrpd_ram #(.WIDTH(5), .DEPTH(MAX_FRAMES)) u_toc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(toc_cnt_r)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (IDX_W'(cur_r)),
    .rdata (ram_rdata)
  );

  assign nb        = {buf_r[6:0], byte_r[7]};
  assign nc        = cnt_r + 4'd1;
  assign cmr_need  = octet_r ? 4'd8 : 4'd4;
  assign toc_need  = octet_r ? 4'd8 : 4'd6;
  assign cmr_ext   = 4'(nb >> (nc - 4'd4));
  assign toc_f     = nb[3'(nc - 4'd1)];
  assign toc_ft    = 4'(nb >> (nc - 4'd5));
  assign toc_q     = nb[3'(nc - 4'd6)];
  assign toc_after = (toc_cnt_r < MAX_C) ? toc_cnt_r + CNT_W'(1) : toc_cnt_r;
  assign left_dec  = left_r - 8'd1;
  assign sp_data   = 8'(nb << (4'd8 - nc));
  assign ev_e      = ram_rdata;
  assign ev_ft     = ev_e[4:1];
  assign ev_nb     = frame_bit_len(ev_ft, octet_r);
  assign err_fin   = err_r | ((phase_r != PH_DONE) ? 2'b10 : 2'b00);
  assign req_fin   = (cmr_r < {1'b0, req_r}) ? cmr_r[2:0] : req_r;
  assign room      = res_n_r < 5'(RES_CAP - 1);
  assign out_free  = !out_valid_r || out_ready;
  assign ram_wdata = {toc_ft, toc_q};

  always_comb begin
    byte_nxt    = byte_r;
    end_nxt     = end_r;
    phase_nxt   = phase_r;
    buf_nxt     = buf_r;
    cnt_nxt     = cnt_r;
    toc_cnt_nxt = toc_cnt_r;
    cur_nxt     = cur_r;
    left_nxt    = left_r;
    cmr_nxt     = cmr_r;
    req_nxt     = req_r;
    err_nxt     = err_r;
    entry_nxt   = entry_r;
    res_n_nxt   = res_n_r;
    sts         = '0;
    emit        = 1'b0;
    e_kind      = KIND_HDR;
    e_data      = 8'd0;
    e_idx       = 4'd0;
    e_ft        = 4'd0;
    e_q         = 1'b0;
    e_last      = 1'b0;
    e_cmr       = 4'd0;
    e_total     = 5'd0;
    e_mode      = 3'd0;
    e_stat      = STAT_OK;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    sts.end_flag = end_r;
    case (cmd.op)
      OP_LOAD: begin
        byte_nxt  = in_byte;
        end_nxt   = in_packet_end;
        res_n_nxt = 5'd0;
      end
      OP_BIT: begin
        byte_nxt = {byte_r[6:0], 1'b0};
        case (phase_r)
          PH_CMR: begin
            if (nc >= cmr_need) begin
              cmr_nxt   = cmr_ext;
              buf_nxt   = 8'd0;
              cnt_nxt   = 4'd0;
              phase_nxt = PH_TOC;
            end else begin
              buf_nxt = nb;
              cnt_nxt = nc;
            end
          end
          PH_TOC: begin
            if (nc >= toc_need) begin
              buf_nxt     = 8'd0;
              cnt_nxt     = 4'd0;
              ram_we      = toc_cnt_r < MAX_C;
              toc_cnt_nxt = toc_after;
              if (toc_f && toc_after >= MAX_C) err_nxt = err_r | 2'b01;
              if (!toc_f || toc_after >= MAX_C) begin
                cur_nxt       = '0;
                sts.open_next = 1'b1;
              end
            end else begin
              buf_nxt = nb;
              cnt_nxt = nc;
            end
          end
          PH_SPEECH: begin
            left_nxt = left_dec;
            if (nc >= 4'd8 || left_dec == 8'd0) begin
              buf_nxt = 8'd0;
              cnt_nxt = 4'd0;
              if (room) begin
                emit      = 1'b1;
                e_kind    = KIND_DATA;
                e_data    = sp_data;
                e_idx     = 4'(cur_r);
                e_ft      = entry_r[4:1];
                e_q       = entry_r[0];
                e_last    = left_dec == 8'd0;
                res_n_nxt = res_n_r + 5'd1;
              end
              if (left_dec == 8'd0) begin
                cur_nxt       = cur_r + CNT_W'(1);
                sts.open_next = 1'b1;
              end
            end else begin
              buf_nxt = nb;
              cnt_nxt = nc;
            end
          end
          default: ;
        endcase
      end
      OP_OPEN_RD: begin
        sts.frame_avail = cur_r < toc_cnt_r;
        ram_re          = sts.frame_avail;
        if (!sts.frame_avail) begin
          left_nxt  = 8'd0;
          buf_nxt   = 8'd0;
          cnt_nxt   = 4'd0;
          phase_nxt = PH_DONE;
        end
      end
      OP_OPEN_EV: begin
        if (ev_ft >= FT_NO_DATA) begin
          cur_nxt        = cur_r + CNT_W'(1);
          sts.ev_advance = 1'b1;
        end else begin
          if (room) begin
            emit      = 1'b1;
            e_kind    = KIND_HDR;
            e_data    = {1'b0, ev_ft, ev_e[0], 2'b00};
            e_idx     = 4'(cur_r);
            e_ft      = ev_ft;
            e_q       = ev_e[0];
            e_last    = ev_nb == 8'd0;
            res_n_nxt = res_n_r + 5'd1;
          end
          if (ev_nb == 8'd0) begin
            cur_nxt        = cur_r + CNT_W'(1);
            sts.ev_advance = 1'b1;
          end else begin
            left_nxt  = ev_nb;
            buf_nxt   = 8'd0;
            cnt_nxt   = 4'd0;
            phase_nxt = PH_SPEECH;
            entry_nxt = ev_e;
          end
        end
      end
      OP_FINISH: begin
        if (end_r) begin
          emit        = 1'b1;
          e_kind      = KIND_SUM;
          e_cmr       = cmr_r;
          e_total     = 5'(toc_cnt_r);
          e_mode      = req_fin;
          e_stat      = err_fin[1] ? STAT_TRUNC : (err_fin[0] ? STAT_OVF : STAT_OK);
          req_nxt     = req_fin;
          phase_nxt   = PH_CMR;
          buf_nxt     = 8'd0;
          cnt_nxt     = 4'd0;
          toc_cnt_nxt = '0;
          cur_nxt     = '0;
          left_nxt    = 8'd0;
          cmr_nxt     = 4'd0;
          err_nxt     = 2'b00;
          end_nxt     = 1'b0;
        end
      end
      default: ;
    endcase
    sts.hold = emit && !out_free;
    if (sts.hold) ram_we = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octet_r   <= 1'b0;
      init_r    <= 3'd7;
      end_r     <= 1'b0;
      phase_r   <= PH_CMR;
      buf_r     <= 8'd0;
      cnt_r     <= 4'd0;
      toc_cnt_r <= '0;
      cur_r     <= '0;
      left_r    <= 8'd0;
      cmr_r     <= 4'd0;
      req_r     <= 3'd7;
      err_r     <= 2'b00;
      res_n_r   <= 5'd0;
    end else begin
      if (!sts.hold) begin
        end_r     <= end_nxt;
        phase_r   <= phase_nxt;
        buf_r     <= buf_nxt;
        cnt_r     <= cnt_nxt;
        toc_cnt_r <= toc_cnt_nxt;
        cur_r     <= cur_nxt;
        left_r    <= left_nxt;
        cmr_r     <= cmr_nxt;
        err_r     <= err_nxt;
        res_n_r   <= res_n_nxt;
      end
      if (cfg.octet_we) octet_r <= cfg.value[0];
      if (cfg.init_we) begin
        init_r <= cfg.value;
        req_r  <= cfg.value;
      end else if (!sts.hold) begin
        req_r  <= req_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!sts.hold) begin
      byte_r  <= byte_nxt;
      entry_r <= entry_nxt;
    end
    if (emit && out_free) begin
      o_kind_r  <= e_kind;
      o_data_r  <= e_data;
      o_idx_r   <= e_idx;
      o_ft_r    <= e_ft;
      o_q_r     <= e_q;
      o_last_r  <= e_last;
      o_cmr_r   <= e_cmr;
      o_total_r <= e_total;
      o_mode_r  <= e_mode;
      o_stat_r  <= e_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign cfg_octet        = octet_r;
  assign cfg_init         = init_r;
  assign out_valid        = out_valid_r;
  assign out_kind         = o_kind_r;
  assign out_data_byte    = o_data_r;
  assign out_frame_index  = o_idx_r;
  assign out_frame_type   = o_ft_r;
  assign out_quality      = o_q_r;
  assign out_frame_last   = o_last_r;
  assign out_cmr_value    = o_cmr_r;
  assign out_frame_total  = o_total_r;
  assign out_req_mode_now = o_mode_r;
  assign out_status       = o_stat_r;

endmodule

// ===== rtl/core/amr_payload_deframer.sv =====
// ----------------------------------------------------------------------------
// amr_payload_deframer
// AMR narrowband payload deframer: CMR and TOC parsing, per-frame header and
// speech byte results, packet summary and requested mode tracking.
// ----------------------------------------------------------------------------
// Each payload byte is taken while idle and its bits are then consumed one
// per cycle, except while a result waits on out_ready; a new byte is taken
// only once all steps of the last one are done. Each TOC entry opened as a
// frame adds one TOC RAM read and one evaluation step, a final read step
// finds the table run out, and the byte marked packet end adds the summary
// step. Results are held in an output register, so the next item is taken
// while a result is still pending.
`include "amr_payload_deframer_macros.svh"

module amr_payload_deframer
  import amrpd_pkg::*;
#(
  parameter int MAX_FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_packet_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [3:0]  out_frame_index,
  output logic [3:0]  out_frame_type,
  output logic        out_quality,
  output logic        out_frame_last,
  output logic [3:0]  out_cmr_value,
  output logic [4:0]  out_frame_total,
  output logic [2:0]  out_req_mode_now,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  amrpd_cmd_t cmd;
  amrpd_sts_t sts;
  amrpd_cfg_t cfg;
  logic       cfg_octet;
  logic [2:0] cfg_init;
  logic       wr_en;

  assign pready       = 1'b1;
  assign wr_en        = psel && penable && pwrite && pready;
  assign cfg.octet_we = wr_en && (paddr[2] == REG_OCTET);
  assign cfg.init_we  = wr_en && (paddr[2] == REG_INIT);
  assign cfg.value    = pwdata[2:0];
  assign prdata       = (paddr[2] == REG_INIT) ? {29'd0, cfg_init} : {31'd0, cfg_octet};

  amrpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  amrpd_dp #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg              (cfg),
    .cfg_octet        (cfg_octet),
    .cfg_init         (cfg_init),
    .in_byte          (in_byte),
    .in_packet_end    (in_packet_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_index  (out_frame_index),
    .out_frame_type   (out_frame_type),
    .out_quality      (out_quality),
    .out_frame_last   (out_frame_last),
    .out_cmr_value    (out_cmr_value),
    .out_frame_total  (out_frame_total),
    .out_req_mode_now (out_req_mode_now),
    .out_status       (out_status)
  );

  `AMR_ASSERT_IMPL(a_ready_op, in_ready, cmd.op == OP_LOAD || cmd.op == OP_NONE)
  `AMR_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `AMR_ASSERT_NEXT(a_hold_keeps_op, sts.hold, $stable(cmd.op))
  `AMR_ASSERT_IMPL(a_hold_out_busy, sts.hold, out_valid && !out_ready)

endmodule

// ===== tb/sv/tb_amr_payload_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_amr_payload_deframer
// Self-checking bench for the AMR payload deframer. A short scripted run
// covers the register extremes, a no-data entry, a truncated packet, a
// header-only frame, a full table and a layout switch inside a packet. Random
// packets follow in several register settings: mostly well-formed payloads
// with random content, some cut short and some plain noise. Every result is
// compared field by field with a bit-level model of the deframer kept here.
// ----------------------------------------------------------------------------
module tb_amr_payload_deframer
  import amrpd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES = 16;
  localparam int IDLE_TAIL  = 80;
  localparam int FT_BIT_LEN [8] = '{95, 103, 118, 134, 148, 159, 204, 244};

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] idx;
    logic [3:0] ft;
    logic       q;
    logic       last;
    logic [3:0] cmr;
    logic [4:0] total;
    logic [2:0] mode;
    logic [1:0] st;
  } deframe_res_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_OCTET, ROW_INIT} row_op_e;

  typedef struct packed {
    row_op_e    op;
    logic [7:0] val;
    logic       fin;
    logic       chk;
    logic [1:0] st;
    logic [3:0] cmr;
    logic [4:0] tot;
  } script_row_t;

  localparam int SCRIPT_LEN = 26;
  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_INIT,  8'h07, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_OCTET, 8'h00, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hF7, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hC0, 1'b1, 1'b1, STAT_OK,    4'd15, 5'd1},
    '{ROW_ITEM,  8'h00, 1'b1, 1'b1, STAT_TRUNC, 4'd0,  5'd0},
    '{ROW_INIT,  8'h07, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'h34, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'h00, 1'b1, 1'b1, STAT_OK,    4'd3,  5'd1},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'hFF, 1'b1, 1'b1, STAT_OVF,   4'd15, 5'd16},
    '{ROW_OCTET, 8'h01, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'h70, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_OCTET, 8'h00, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0},
    '{ROW_ITEM,  8'h44, 1'b1, 1'b1, STAT_OK,    4'd7,  5'd1},
    '{ROW_INIT,  8'h00, 1'b0, 1'b0, STAT_OK,    4'd0,  5'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_packet_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [3:0]  out_frame_index;
  logic [3:0]  out_frame_type;
  logic        out_quality;
  logic        out_frame_last;
  logic [3:0]  out_cmr_value;
  logic [4:0]  out_frame_total;
  logic [2:0]  out_req_mode_now;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  amr_payload_deframer #(.MAX_FRAMES(MAX_FRAMES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_byte(in_byte), .in_packet_end(in_packet_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_data_byte(out_data_byte),
    .out_frame_index(out_frame_index), .out_frame_type(out_frame_type),
    .out_quality(out_quality), .out_frame_last(out_frame_last),
    .out_cmr_value(out_cmr_value), .out_frame_total(out_frame_total),
    .out_req_mode_now(out_req_mode_now), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // deframer model state
  logic        octet_r;
  logic [1:0]  phase_r;
  logic [15:0] gath;
  int          gath_n;
  logic [4:0]  toc_q [MAX_FRAMES];
  int          toc_n;
  int          cur_frame;
  int          left;
  logic [3:0]  cmr_k;
  logic [2:0]  kept_mode;
  logic        ovf;
  logic        trunc;
  int          step_n;

  deframe_res_t due_results [$];
  bit           pkt_bits [$];

  int  fails = 0;
  int  items_sent = 0;
  int  n_hdr = 0, n_data = 0, n_sum = 0, n_ovf = 0, n_trunc = 0;
  int  out_hold = 0;
  bit  quiet = 1'b0;

  function automatic int frame_bits(logic [3:0] ft, logic oct);
    int n;
    if (ft > 4'd7) return 0;
    n = FT_BIT_LEN[ft];
    if (oct) n = (n + 7) / 8 * 8;
    return n;
  endfunction

  function automatic void clear_packet();
    phase_r = PH_CMR;
    gath = '0;
    gath_n = 0;
    toc_n = 0;
    cur_frame = 0;
    left = 0;
    cmr_k = '0;
    ovf = 1'b0;
    trunc = 1'b0;
  endfunction

  function automatic void emit_frame(logic [1:0] kind, logic [7:0] data, logic last);
    deframe_res_t r;
    if (step_n >= RES_CAP - 1 || cur_frame >= MAX_FRAMES) return;
    r = '0;
    r.kind = kind;
    r.data = data;
    r.idx = cur_frame[3:0];
    r.ft = toc_q[cur_frame][4:1];
    r.q = toc_q[cur_frame][0];
    r.last = last;
    due_results.push_back(r);
    step_n++;
  endfunction

  function automatic void open_frames();
    logic [4:0] e;
    int nb;
    while (cur_frame < toc_n) begin
      e = toc_q[cur_frame];
      if (e[4:1] >= FT_NO_DATA) begin
        cur_frame++;
        continue;
      end
      nb = frame_bits(e[4:1], octet_r);
      emit_frame(KIND_HDR, {1'b0, e[4:1], e[0], 2'b00}, nb == 0);
      if (nb == 0) begin
        cur_frame++;
        continue;
      end
      left = nb;
      gath = '0;
      gath_n = 0;
      phase_r = PH_SPEECH;
      return;
    end
    left = 0;
    gath = '0;
    gath_n = 0;
    phase_r = PH_DONE;
  endfunction

  function automatic void absorb_bit(logic b);
    int need;
    logic f;
    logic [3:0] ft;
    logic q;
    logic [15:0] sh;
    if (phase_r == PH_DONE) return;
    gath = {gath[14:0], b};
    gath_n++;
    case (phase_r)
      PH_CMR: begin
        need = octet_r ? 8 : 4;
        if (gath_n >= need) begin
          sh = gath >> (gath_n - 4);
          cmr_k = sh[3:0];
          gath = '0;
          gath_n = 0;
          phase_r = PH_TOC;
        end
      end
      PH_TOC: begin
        need = octet_r ? 8 : 6;
        if (gath_n >= need) begin
          sh = gath >> (gath_n - 1);
          f = sh[0];
          sh = gath >> (gath_n - 5);
          ft = sh[3:0];
          sh = gath >> (gath_n - 6);
          q = sh[0];
          gath = '0;
          gath_n = 0;
          if (toc_n < MAX_FRAMES) begin
            toc_q[toc_n] = {ft, q};
            toc_n++;
          end
          if (f && toc_n >= MAX_FRAMES) ovf = 1'b1;
          if (!f || toc_n >= MAX_FRAMES) begin
            cur_frame = 0;
            open_frames();
          end
        end
      end
      default: begin
        left = (left - 1) & 255;
        if (gath_n >= 8 || left == 0) begin
          sh = gath << (8 - gath_n);
          gath = '0;
          gath_n = 0;
          emit_frame(KIND_DATA, sh[7:0], left == 0);
          if (left == 0) begin
            cur_frame++;
            open_frames();
          end
        end
      end
    endcase
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic fin);
    deframe_res_t r;
    step_n = 0;
    for (int i = 7; i >= 0; i--) absorb_bit(b[i]);
    if (fin) begin
      if (phase_r != PH_DONE) trunc = 1'b1;
      if (cmr_k < {1'b0, kept_mode}) kept_mode = cmr_k[2:0];
      r = '0;
      r.kind = KIND_SUM;
      r.cmr = cmr_k;
      r.total = toc_n[4:0];
      r.mode = kept_mode;
      r.st = trunc ? STAT_TRUNC : (ovf ? STAT_OVF : STAT_OK);
      due_results.push_back(r);
      clear_packet();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  function automatic void push_field(int v, int w);
    for (int i = w - 1; i >= 0; i--) pkt_bits.push_back(v[i]);
  endfunction

  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
      out_hold = pick_gap();
    end
  end

  always @(negedge clk) begin
    deframe_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result with nothing pending: kind %0d data %02h", out_kind, out_data_byte);
        fails++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("data_byte", want.data, out_data_byte);
        check_field("frame_index", want.idx, out_frame_index);
        check_field("frame_type", want.ft, out_frame_type);
        check_field("quality", want.q, out_quality);
        check_field("frame_last", want.last, out_frame_last);
        check_field("cmr_value", want.cmr, out_cmr_value);
        check_field("frame_total", want.total, out_frame_total);
        check_field("req_mode_now", want.mode, out_req_mode_now);
        check_field("status", want.st, out_status);
        case (want.kind)
          KIND_HDR:  n_hdr++;
          KIND_DATA: n_data++;
          default: begin
            n_sum++;
            if (want.st == STAT_OVF) n_ovf++;
            if (want.st == STAT_TRUNC) n_trunc++;
          end
        endcase
      end
    end
  end

  task automatic put_item(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_packet_end <= fin;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    deframe_byte(b, fin);
    items_sent++;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (due_results.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      fails++;
      due_results.delete();
    end
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] value);
    settle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {29'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_OCTET) begin
      octet_r = value[0];
    end else begin
      kept_mode = value;
    end
  endtask

  task automatic send_packet();
    int r, n, nb, keep;
    logic [3:0] ft;
    logic [3:0] fts [$];
    logic [7:0] bytes [$];
    logic [7:0] acc;
    bit over;
    pkt_bits.delete();
    quiet = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++)
        put_item(8'($urandom_range(0, 255)), k == n - 1 || $urandom_range(0, 2) == 0);
      return;
    end
    over = (r < 18);
    push_field($urandom_range(0, 15), 4);
    if (octet_r) push_field($urandom_range(0, 15), 4);
    n = over ? MAX_FRAMES : $urandom_range(1, 3);
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (over) ft = (r < 88) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 3));
      else if (r < 35) ft = 4'($urandom_range(8, 15));
      else if (r < 80) ft = 4'($urandom_range(0, 3));
      else ft = 4'($urandom_range(4, 7));
      fts.push_back(ft);
      push_field(over || j != n - 1, 1);
      push_field(ft, 4);
      push_field($urandom_range(0, 1), 1);
      if (octet_r) push_field($urandom_range(0, 3), 2);
    end
    foreach (fts[j]) begin
      if (fts[j] < FT_NO_DATA) begin
        nb = frame_bits(fts[j], octet_r);
        for (int k = 0; k < nb; k++) pkt_bits.push_back(1'($urandom_range(0, 1)));
      end
    end
    while (pkt_bits.size() % 8 != 0) pkt_bits.push_back(1'($urandom_range(0, 1)));
    if ($urandom_range(0, 4) == 0) push_field($urandom_range(0, 255), 8);
    for (int k = 0; k < pkt_bits.size(); k += 8) begin
      for (int m = 0; m < 8; m++) acc = {acc[6:0], pkt_bits[k + m]};
      bytes.push_back(acc);
    end
    keep = bytes.size();
    if (keep > 1 && $urandom_range(0, 99) < 15) keep = $urandom_range(1, keep - 1);
    for (int k = 0; k < keep; k++) put_item(bytes[k], k == keep - 1);
  endtask

  initial begin
    octet_r = 1'b0;
    kept_mode = 3'd7;
    clear_packet();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      case (script[i].op)
        ROW_OCTET: write_reg(REG_OCTET, script[i].val[2:0]);
        ROW_INIT:  write_reg(REG_INIT, script[i].val[2:0]);
        default: begin
          put_item(script[i].val, script[i].fin);
          if (script[i].chk && (due_results[$].st != script[i].st ||
              due_results[$].cmr != script[i].cmr || due_results[$].total != script[i].tot)) begin
            $error("script row %0d: summary differs from the typed values", i);
            fails++;
          end
        end
      endcase
    end

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_OCTET, {2'b00, ph[0]});
      write_reg(REG_INIT, (ph == 1) ? 3'd0 : (ph == 2) ? 3'd7 : 3'($urandom_range(0, 7)));
      while (items_sent < 20 + (ph + 1) * 88) send_packet();
    end
    quiet = 1'b0;
    settle();

    $display("Sent %0d payload bytes; checked %0d headers, %0d speech bytes, %0d summaries",
             items_sent, n_hdr, n_data, n_sum);
    $display("Summaries with table overflow: %0d, with truncation: %0d", n_ovf, n_trunc);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
